// ===== hw/rtl/flt_pkg.sv =====
// shared types and constants for the flow table with aging
// used by flt_ctrl, flt_dp and flow_table_with_aging_unit; no dependencies
`default_nettype none

package flt_pkg;

	localparam int unsigned MAX_FLOWS_DEF = 64;

	localparam int unsigned KEY_W   = 32;
	localparam int unsigned HITS_W  = 32;
	localparam int unsigned INDEX_W = 6;
	localparam int unsigned COUNT_W = 7;

	typedef enum logic {
		REQ_LOOKUP = 1'b0,
		REQ_SWEEP  = 1'b1
	} req_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_LOOKUP,
		ST_SWEEP,
		ST_DONE
	} state_t;

	// one table entry as held in the entry memory
	typedef struct packed {
		logic [KEY_W-1:0]  key;
		logic              recent;
		logic [HITS_W-1:0] hits;
	} entry_t;

	// controller to datapath
	typedef struct packed {
		logic start;
		logic scan;
		logic hit_wr;
		logic miss_fin;
		logic sweep_keep;
		logic sweep_fin;
		logic out_load;
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic key_match;
		logic scan_end;
	} sts_t;

endpackage

`default_nettype wire

// ===== hw/rtl/flt_ctrl.sv =====
// controller state machine of the flow table
// depends on flt_pkg; drives flt_dp through cmd_t and reads sts_t
`default_nettype none

module flt_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  logic          req_type,
	output logic          out_valid,
	input  logic          out_ready,
	input  flt_pkg::sts_t sts,
	output flt_pkg::cmd_t cmd
);
	import flt_pkg::*;

	state_t state_q;
	state_t state_d;
	logic   out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.start = 1'b1;
					state_d   = (req_type == REQ_SWEEP) ? ST_SWEEP : ST_LOOKUP;
				end
			end
			ST_LOOKUP: begin
				if (sts.key_match) begin
					cmd.hit_wr = 1'b1;
					state_d    = ST_DONE;
				end else if (sts.scan_end) begin
					cmd.miss_fin = 1'b1;
					state_d      = ST_DONE;
				end else begin
					cmd.scan = 1'b1;
				end
			end
			ST_SWEEP: begin
				cmd.scan       = 1'b1;
				cmd.sweep_keep = 1'b1;
				if (sts.scan_end) begin
					cmd.sweep_fin = 1'b1;
					state_d       = ST_DONE;
				end
			end
			ST_DONE: begin
				// wait for the output register to be free
				if (!out_valid_q || out_ready) begin
					cmd.out_load = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	assign out_valid = out_valid_q;

endmodule

`default_nettype wire

// ===== hw/rtl/flt_dp.sv =====
// datapath of the flow table: entry memory, scan pipeline, result registers
// depends on flt_pkg; controlled by flt_ctrl
`default_nettype none

module flt_dp #(
	parameter int unsigned MAX_FLOWS = flt_pkg::MAX_FLOWS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  flt_pkg::cmd_t                cmd,
	output flt_pkg::sts_t                sts,
	input  logic [flt_pkg::KEY_W-1:0]    peer_addr,
	output logic                         hit,
	output logic [flt_pkg::INDEX_W-1:0]  flow_index,
	output logic [flt_pkg::HITS_W-1:0]   hit_count,
	output logic                         table_full,
	output logic [flt_pkg::COUNT_W-1:0]  active_count,
	output logic [flt_pkg::COUNT_W-1:0]  removed_count
);
	import flt_pkg::*;

	localparam int unsigned IDX_W = (MAX_FLOWS > 1) ? $clog2(MAX_FLOWS) : 1;
	localparam int unsigned CNT_W = $clog2(MAX_FLOWS + 1);

	entry_t            entry_mem_q [MAX_FLOWS];
	entry_t            rd_s1;
	logic              chk_vld_s1;
	logic [IDX_W-1:0]  chk_idx_s1;

	logic [KEY_W-1:0]  key_q;
	logic [CNT_W-1:0]  used_q;
	logic [CNT_W-1:0]  ix_q;
	logic [CNT_W-1:0]  kept_q;

	logic              issue;
	logic              keep;
	logic              full;
	logic [HITS_W-1:0] hits_inc;
	logic              wr_en;
	logic [IDX_W-1:0]  wr_addr;
	entry_t            wr_data;

	logic              res_hit_q;
	logic [IDX_W-1:0]  res_idx_q;
	logic [HITS_W-1:0] res_hits_q;
	logic              res_full_q;
	logic [CNT_W-1:0]  res_active_q;
	logic [CNT_W-1:0]  res_removed_q;

	logic               hit_q;
	logic [INDEX_W-1:0] flow_index_q;
	logic [HITS_W-1:0]  hit_count_q;
	logic               table_full_q;
	logic [COUNT_W-1:0] active_count_q;
	logic [COUNT_W-1:0] removed_count_q;

	always_comb begin
		issue         = cmd.scan && (ix_q < used_q);
		sts.key_match = chk_vld_s1 && (rd_s1.key == key_q);
		sts.scan_end  = (ix_q == used_q) && !chk_vld_s1;
		full          = (used_q == CNT_W'(MAX_FLOWS));
		keep          = cmd.sweep_keep && chk_vld_s1 && rd_s1.recent;
		hits_inc      = (rd_s1.hits == '1) ? rd_s1.hits : rd_s1.hits + HITS_W'(1);

		wr_en   = 1'b0;
		wr_addr = chk_idx_s1;
		wr_data = rd_s1;
		priority if (cmd.hit_wr) begin
			wr_en   = 1'b1;
			wr_data = '{key: key_q, recent: 1'b1, hits: hits_inc};
		end else if (cmd.miss_fin && !full) begin
			wr_en   = 1'b1;
			wr_addr = used_q[IDX_W-1:0];
			wr_data = '{key: key_q, recent: 1'b1, hits: HITS_W'(1)};
		end else if (keep) begin
			// survivor moves down to the next dense slot, recent bit cleared
			wr_en   = 1'b1;
			wr_addr = kept_q[IDX_W-1:0];
			wr_data = '{key: rd_s1.key, recent: 1'b0, hits: rd_s1.hits};
		end
	end

	// entry memory, one write and one registered read per cycle
	always_ff @(posedge clk) begin
		if (wr_en) begin
			entry_mem_q[wr_addr] <= wr_data;
		end
		rd_s1      <= entry_mem_q[ix_q[IDX_W-1:0]];
		chk_idx_s1 <= ix_q[IDX_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q     <= '0;
			ix_q       <= '0;
			kept_q     <= '0;
			chk_vld_s1 <= 1'b0;
		end else begin
			if (cmd.start) begin
				ix_q       <= '0;
				kept_q     <= '0;
				chk_vld_s1 <= 1'b0;
			end else begin
				chk_vld_s1 <= issue;
				if (issue) begin
					ix_q <= ix_q + CNT_W'(1);
				end
				if (keep) begin
					kept_q <= kept_q + CNT_W'(1);
				end
			end
			if (cmd.miss_fin && !full) begin
				used_q <= used_q + CNT_W'(1);
			end else if (cmd.sweep_fin) begin
				used_q <= kept_q;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			key_q <= peer_addr;
		end
		if (cmd.hit_wr) begin
			res_hit_q     <= 1'b1;
			res_idx_q     <= chk_idx_s1;
			res_hits_q    <= hits_inc;
			res_full_q    <= 1'b0;
			res_active_q  <= used_q;
			res_removed_q <= '0;
		end else if (cmd.miss_fin) begin
			res_hit_q     <= 1'b0;
			res_removed_q <= '0;
			if (full) begin
				res_idx_q    <= '0;
				res_hits_q   <= '0;
				res_full_q   <= 1'b1;
				res_active_q <= used_q;
			end else begin
				res_idx_q    <= used_q[IDX_W-1:0];
				res_hits_q   <= HITS_W'(1);
				res_full_q   <= 1'b0;
				res_active_q <= used_q + CNT_W'(1);
			end
		end else if (cmd.sweep_fin) begin
			res_hit_q     <= 1'b0;
			res_idx_q     <= '0;
			res_hits_q    <= '0;
			res_full_q    <= 1'b0;
			res_active_q  <= kept_q;
			res_removed_q <= used_q - kept_q;
		end
		if (cmd.out_load) begin
			hit_q           <= res_hit_q;
			flow_index_q    <= INDEX_W'(res_idx_q);
			hit_count_q     <= res_hits_q;
			table_full_q    <= res_full_q;
			active_count_q  <= COUNT_W'(res_active_q);
			removed_count_q <= COUNT_W'(res_removed_q);
		end
	end

	assign hit           = hit_q;
	assign flow_index    = flow_index_q;
	assign hit_count     = hit_count_q;
	assign table_full    = table_full_q;
	assign active_count  = active_count_q;
	assign removed_count = removed_count_q;

endmodule

`default_nettype wire

// ===== hw/rtl/flow_table_with_aging_unit.sv =====
// top level of the flow table with aging sweep
// depends on flt_pkg, flt_ctrl and flt_dp
`default_nettype none

// Dense flow table of up to MAX_FLOWS entries keyed by a 32-bit peer address,
// with one result transaction for every input transaction. A lookup
// (req_type 0) scans the active entries in index order through the single
// read port of the entry memory, one entry per cycle; a hit sets the recent
// bit and bumps the saturating hit count, a miss appends a new entry with a
// count of 1, or raises table_full when every slot is taken. An aging sweep
// (req_type 1) walks the same memory once, moving every entry with its recent
// bit set down to the next dense slot and clearing the bit, then reports the
// new count and how many entries went away. One transaction is in work at a
// time: a lookup that hits at index i ends its scan at that entry, a miss or
// a sweep reads all n active entries, so the entry scan sets the rate. The
// finished result sits in an output register and the next input transaction
// is taken while it waits; only the completion of the following one stalls
// until the output is free. The table needs no clearing pass after reset:
// only entries below the active count are ever used, and each of them was
// written first.

module flow_table_with_aging_unit #(
	parameter int unsigned MAX_FLOWS = flt_pkg::MAX_FLOWS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	// input transactions
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic                         req_type,
	input  logic [flt_pkg::KEY_W-1:0]    peer_addr,
	// result transactions
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic                         hit,
	output logic [flt_pkg::INDEX_W-1:0]  flow_index,
	output logic [flt_pkg::HITS_W-1:0]   hit_count,
	output logic                         table_full,
	output logic [flt_pkg::COUNT_W-1:0]  active_count,
	output logic [flt_pkg::COUNT_W-1:0]  removed_count
);
	import flt_pkg::*;

	cmd_t cmd;
	sts_t sts;

	// sequencing: accept, scan, finish, hand result to output register
	flt_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.req_type  (req_type),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	// entry memory, scan pipeline, compaction and result registers
	flt_dp #(
		.MAX_FLOWS (MAX_FLOWS)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.sts           (sts),
		.peer_addr     (peer_addr),
		.hit           (hit),
		.flow_index    (flow_index),
		.hit_count     (hit_count),
		.table_full    (table_full),
		.active_count  (active_count),
		.removed_count (removed_count)
	);

endmodule

`default_nettype wire
